FILE: sv/saturating_register_alu_machine_assert.svh
// ----------------------------------------------------------------------------
// saturating register alu machine assertion macros
// clocked property checks, compiled away when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef SATURATING_REGISTER_ALU_MACHINE_ASSERT_SVH
`define SATURATING_REGISTER_ALU_MACHINE_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define SRALU_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// consequent holds in the cycle after the antecedent
`define SRALU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRALU_ASSERT(name, prop, msg)
`define SRALU_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: sv/sralu_pkg.sv
// ----------------------------------------------------------------------------
// sralu_pkg
// shared types and constants of the saturating register alu machine
// ----------------------------------------------------------------------------
package sralu_pkg;

    localparam int REG_COUNT_DEFAULT  = 16;
    localparam int VALUE_BITS_DEFAULT = 8;

    localparam int FIELD_BITS    = 8;
    localparam int IDX_BITS      = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int S_TDATA_BITS  = 24;
    localparam int S_TUSER_BITS  = 2;
    localparam int M_TDATA_BITS  = 16;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic signed [FIELD_BITS-1:0] UPPER_RESET = 8'h7f;
    localparam logic signed [FIELD_BITS-1:0] LOWER_RESET = 8'h80;

    // register index, taken from paddr[2]
    localparam logic CFG_IDX_UPPER = 1'b0;
    localparam logic CFG_IDX_LOWER = 1'b1;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        K_NOP,
        K_CLEAR,
        K_LOAD,
        K_EXEC
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLAMP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_kind                         kind;
        t_op                           op;
        logic [IDX_BITS-1:0]           dst;
        logic [IDX_BITS-1:0]           src_a;
        logic [IDX_BITS-1:0]           src_b;
        logic signed [FIELD_BITS-1:0]  load_value;
    } t_cmd;

endpackage

FILE: sv/sralu_front.sv
// ----------------------------------------------------------------------------
// sralu_front
// accepts input transfers, classifies them and queues the commands
// ----------------------------------------------------------------------------
`include "saturating_register_alu_machine_assert.svh"

module sralu_front #(
    parameter int REG_COUNT = sralu_pkg::REG_COUNT_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // target_index[3:0], opcode[5:4], first_source[9:6], second_source[13:10],
    // load_value[21:14], zero pad
    input  logic [sralu_pkg::S_TDATA_BITS-1:0]    i_s_tdata,
    // mode[1:0]
    input  logic [sralu_pkg::S_TUSER_BITS-1:0]    i_s_tuser,
    output logic                                  o_cmd_valid,
    input  logic                                  i_cmd_ready,
    output sralu_pkg::t_cmd                       o_cmd
);

    localparam int PTR_BITS = (sralu_pkg::QUEUE_DEPTH > 1) ? $clog2(sralu_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(sralu_pkg::QUEUE_DEPTH + 1);
    localparam logic [6:0] RC = 7'(REG_COUNT);

    sralu_pkg::t_cmd      r_q [sralu_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;

    logic [3:0]           dst;
    logic [3:0]           src_a;
    logic [3:0]           src_b;
    logic                 dst_ok;
    logic                 srcs_ok;
    sralu_pkg::t_cmd      cmd_in;
    logic                 push;
    logic                 pop;

    assign dst   = i_s_tdata[3:0];
    assign src_a = i_s_tdata[9:6];
    assign src_b = i_s_tdata[13:10];

    assign dst_ok  = ({3'b000, dst} < RC);
    assign srcs_ok = ({3'b000, src_a} < RC) && ({3'b000, src_b} < RC);

    always_comb begin
        cmd_in.op         = sralu_pkg::t_op'(i_s_tdata[5:4]);
        cmd_in.dst        = dst;
        cmd_in.src_a      = src_a;
        cmd_in.src_b      = src_b;
        cmd_in.load_value = i_s_tdata[21:14];
        case (i_s_tuser)
            sralu_pkg::MODE_CLEAR: cmd_in.kind = sralu_pkg::K_CLEAR;
            sralu_pkg::MODE_LOAD:  cmd_in.kind = dst_ok ? sralu_pkg::K_LOAD : sralu_pkg::K_NOP;
            sralu_pkg::MODE_EXEC: begin
                cmd_in.kind = (dst_ok && srcs_ok) ? sralu_pkg::K_EXEC : sralu_pkg::K_NOP;
            end
            default:               cmd_in.kind = sralu_pkg::K_NOP;
        endcase
    end

    assign o_s_tready  = (r_count < CNT_BITS'(sralu_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    assign push = i_s_tvalid && o_s_tready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    // pointers wrap on their own as the depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CNT_BITS'(1);
                2'b01:   r_count <= r_count - CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `SRALU_ASSERT(a_count_max, r_count <= CNT_BITS'(sralu_pkg::QUEUE_DEPTH), "queue overfilled")
    `SRALU_ASSERT_NEXT(a_push_grows, push && !pop, r_count == $past(r_count) + CNT_BITS'(1), "push lost")
    `SRALU_ASSERT_NEXT(a_pop_shrinks, pop && !push, r_count == $past(r_count) - CNT_BITS'(1), "pop lost")

endmodule

FILE: sv/sralu_div.sv
// ----------------------------------------------------------------------------
// sralu_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module sralu_div #(
    parameter int W = sralu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [W-1:0]  i_dividend,
    input  logic signed [W-1:0]  i_divisor,
    output logic                 o_done,
    output logic signed [W-1:0]  o_quotient
);

    localparam int CNT_BITS = $clog2(W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [W:0]           r_rem;
    logic [W-1:0]         r_quo;
    logic [W-1:0]         r_den;
    logic                 r_neg;

    logic [W-1:0]         mag_a;
    logic [W-1:0]         mag_b;
    logic [W:0]           shifted;
    logic [W:0]           trial;

    // most negative value maps onto its own bit pattern, read as unsigned
    assign mag_a   = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
    assign mag_b   = i_divisor[W-1]  ? W'(-i_divisor)  : W'(i_divisor);
    assign shifted = {r_rem[W-1:0], r_quo[W-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_den <= mag_b;
            r_neg <= i_dividend[W-1] ^ i_divisor[W-1];
        end else if (r_busy) begin
            if (!trial[W]) begin
                r_rem <= trial;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

FILE: sv/sralu_back.sv
// ----------------------------------------------------------------------------
// sralu_back
// executes queued commands on the register file and holds the result transfer
// ----------------------------------------------------------------------------
`include "saturating_register_alu_machine_assert.svh"

module sralu_back #(
    parameter int REG_COUNT  = sralu_pkg::REG_COUNT_DEFAULT,
    parameter int VALUE_BITS = sralu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_valid,
    output logic                                  o_cmd_ready,
    input  sralu_pkg::t_cmd                       i_cmd,
    input  logic signed [sralu_pkg::FIELD_BITS-1:0] i_upper,
    input  logic signed [sralu_pkg::FIELD_BITS-1:0] i_lower,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // register_a_value[7:0], written_value[15:8]
    output logic [sralu_pkg::M_TDATA_BITS-1:0]    o_m_tdata
);

    localparam int VB = VALUE_BITS;
    localparam int IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int CW = 2 * VB + 1;
    localparam int FB = sralu_pkg::FIELD_BITS;

    localparam logic signed [VB-1:0] VMAX_V = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN_V = {1'b1, {(VB-1){1'b0}}};
    localparam logic signed [CW-1:0] VMAX_W = {{(CW-VB){1'b0}}, VMAX_V};
    localparam logic signed [CW-1:0] VMIN_W = {{(CW-VB){1'b1}}, VMIN_V};

    sralu_pkg::t_state         r_state;
    sralu_pkg::t_state         n_state;

    logic signed [VB-1:0]      r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]      r_valid;
    logic signed [VB-1:0]      r_reg0;

    sralu_pkg::t_cmd           r_cmd;
    logic signed [VB-1:0]      r_rd_a;
    logic signed [VB-1:0]      r_rd_b;
    logic                      r_va;
    logic                      r_vb;
    logic signed [CW-1:0]      r_wide;
    logic                      r_limit;
    logic signed [VB-1:0]      r_res;

    logic                      r_out_valid;
    logic [FB-1:0]             r_out_a;
    logic [FB-1:0]             r_out_w;

    logic                      pop;
    logic                      fire;
    logic                      div_start;
    logic                      div_done;
    logic signed [VB-1:0]      div_q;
    logic                      out_free;

    logic signed [VB-1:0]      op_a;
    logic signed [VB-1:0]      op_b;
    logic signed [CW-1:0]      op_a_w;
    logic signed [CW-1:0]      op_b_w;
    logic signed [2*VB-1:0]    prod;
    logic signed [CW-1:0]      wide_sel;
    logic                      is_div;
    logic                      div_special;

    logic signed [CW-1:0]      up_w;
    logic signed [CW-1:0]      lo_w;
    logic signed [CW-1:0]      lim_w;
    logic signed [CW-1:0]      fit_w;

    logic                      wr_en;
    logic signed [VB-1:0]      written;
    logic signed [VB-1:0]      reg0_next;
    logic [VB+FB-1:0]          reg0_ext;
    logic [VB+FB-1:0]          written_ext;

    // operands: entries not written since the last clear read as zero
    assign op_a   = r_va ? r_rd_a : '0;
    assign op_b   = r_vb ? r_rd_b : '0;
    assign op_a_w = {{(CW-VB){op_a[VB-1]}}, op_a};
    assign op_b_w = {{(CW-VB){op_b[VB-1]}}, op_b};
    assign prod   = op_a * op_b;

    assign is_div      = (r_cmd.kind == sralu_pkg::K_EXEC) && (r_cmd.op == sralu_pkg::OP_DIV);
    assign div_special = (op_b == '0) || ((op_a == VMIN_V) && (op_b == '1));

    always_comb begin
        if (r_cmd.kind == sralu_pkg::K_LOAD) begin
            wide_sel = {{(CW-FB){r_cmd.load_value[FB-1]}}, r_cmd.load_value};
        end else begin
            case (r_cmd.op)
                sralu_pkg::OP_ADD: wide_sel = op_a_w + op_b_w;
                sralu_pkg::OP_SUB: wide_sel = op_a_w - op_b_w;
                sralu_pkg::OP_MUL: wide_sel = {prod[2*VB-1], prod};
                default:           wide_sel = op_a_w;
            endcase
        end
    end

    // ceiling first, then floor, then the register range
    assign up_w  = {{(CW-FB){i_upper[FB-1]}}, i_upper};
    assign lo_w  = {{(CW-FB){i_lower[FB-1]}}, i_lower};
    assign lim_w = !r_limit       ? r_wide :
                   (r_wide > up_w) ? up_w  :
                   (r_wide < lo_w) ? lo_w  : r_wide;
    assign fit_w = (lim_w > VMAX_W) ? VMAX_W :
                   (lim_w < VMIN_W) ? VMIN_W : lim_w;

    assign out_free  = !r_out_valid || i_m_tready;
    assign wr_en     = r_cmd.kind inside {sralu_pkg::K_LOAD, sralu_pkg::K_EXEC};
    assign written   = wr_en ? r_res : '0;
    assign reg0_next = (r_cmd.kind == sralu_pkg::K_CLEAR)            ? '0    :
                       (wr_en && (r_cmd.dst == '0))                  ? r_res : r_reg0;
    assign reg0_ext    = {{FB{reg0_next[VB-1]}}, reg0_next};
    assign written_ext = {{FB{written[VB-1]}}, written};

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        fire      = 1'b0;
        div_start = 1'b0;
        case (r_state)
            sralu_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    pop     = 1'b1;
                    n_state = sralu_pkg::ST_EXEC;
                end
            end
            sralu_pkg::ST_EXEC: begin
                if (is_div) begin
                    if (div_special) begin
                        n_state = sralu_pkg::ST_DONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = sralu_pkg::ST_DIV;
                    end
                end else if (wr_en) begin
                    n_state = sralu_pkg::ST_CLAMP;
                end else begin
                    n_state = sralu_pkg::ST_DONE;
                end
            end
            sralu_pkg::ST_CLAMP: n_state = sralu_pkg::ST_DONE;
            sralu_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = sralu_pkg::ST_DONE;
                end
            end
            sralu_pkg::ST_DONE: begin
                if (out_free) begin
                    fire    = 1'b1;
                    n_state = sralu_pkg::ST_IDLE;
                end
            end
            default: n_state = sralu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sralu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // register file and operand reads
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd  <= i_cmd;
            r_rd_a <= r_mem[IW'(i_cmd.src_a)];
            r_rd_b <= r_mem[IW'(i_cmd.src_b)];
            r_va   <= r_valid[IW'(i_cmd.src_a)];
            r_vb   <= r_valid[IW'(i_cmd.src_b)];
        end
        if (fire && wr_en) begin
            r_mem[IW'(r_cmd.dst)] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sralu_pkg::ST_EXEC: begin
                r_wide  <= wide_sel;
                r_limit <= (r_cmd.kind == sralu_pkg::K_EXEC);
                if (is_div) begin
                    r_res <= (op_b == '0) ? op_a : VMAX_V;
                end else begin
                    r_res <= '0;
                end
            end
            sralu_pkg::ST_CLAMP: r_res <= fit_w[VB-1:0];
            sralu_pkg::ST_DIV: begin
                if (div_done) begin
                    r_res <= div_q;
                end
            end
            default: r_res <= r_res;
        endcase
        if (fire) begin
            r_out_a <= reg0_ext[FB-1:0];
            r_out_w <= written_ext[FB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_reg0      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_reg0      <= reg0_next;
                r_out_valid <= 1'b1;
                if (r_cmd.kind == sralu_pkg::K_CLEAR) begin
                    r_valid <= '0;
                end else if (wr_en) begin
                    r_valid[IW'(r_cmd.dst)] <= 1'b1;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    sralu_div #(
        .W (VB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (op_a),
        .i_divisor  (op_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_cmd_ready = (r_state == sralu_pkg::ST_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {r_out_w, r_out_a};

    `SRALU_ASSERT_NEXT(a_div_to_done, r_state == sralu_pkg::ST_DIV && div_done, r_state == sralu_pkg::ST_DONE, "divide result dropped")
    `SRALU_ASSERT_NEXT(a_fire_out, fire, o_m_tvalid && r_state == sralu_pkg::ST_IDLE, "result not presented")
    `SRALU_ASSERT_NEXT(a_clear_all, fire && r_cmd.kind == sralu_pkg::K_CLEAR, r_valid == '0 && r_reg0 == '0, "clear incomplete")

endmodule

FILE: sv/saturating_register_alu_machine.sv
// ----------------------------------------------------------------------------
// saturating_register_alu_machine
// sixteen-register saturating alu machine with stream ports and apb registers
// ----------------------------------------------------------------------------
// Each input transfer clears the registers, loads one register or runs an
// add, subtract, multiply or divide command, and gives exactly one result
// transfer with register zero and the value written. The front queues up to
// two classified commands, so input transfers are taken while a result waits.
// A command in the back passes the execute state, then the clamp state for
// a load, add, subtract or multiply, the divide state for any other divide,
// where the divider produces one quotient bit per cycle, or the done state
// directly for a clear, an ignored item, a divide by zero or the one divide
// overflow. The clamp limits are to be written through the apb port only while
// the block is idle, which it does not enforce; no clearing pass follows reset.
module saturating_register_alu_machine #(
    parameter int REG_COUNT  = sralu_pkg::REG_COUNT_DEFAULT,
    parameter int VALUE_BITS = sralu_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // target_index[3:0], opcode[5:4], first_source[9:6], second_source[13:10],
    // load_value[21:14], zero pad
    input  logic [sralu_pkg::S_TDATA_BITS-1:0]    s_axis_tdata,
    // mode[1:0]
    input  logic [sralu_pkg::S_TUSER_BITS-1:0]    s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // register_a_value[7:0], written_value[15:8]
    output logic [sralu_pkg::M_TDATA_BITS-1:0]    m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [sralu_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [sralu_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [sralu_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                  pready
);

    localparam int FB = sralu_pkg::FIELD_BITS;
    localparam int DB = sralu_pkg::CFG_DATA_BITS;

    logic signed [FB-1:0]  r_upper;
    logic signed [FB-1:0]  r_lower;
    logic                  cfg_wr;
    logic                  cmd_valid;
    logic                  cmd_ready;
    sralu_pkg::t_cmd       cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= sralu_pkg::UPPER_RESET;
            r_lower <= sralu_pkg::LOWER_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                sralu_pkg::CFG_IDX_UPPER: r_upper <= pwdata[FB-1:0];
                sralu_pkg::CFG_IDX_LOWER: r_lower <= pwdata[FB-1:0];
                default:                  r_upper <= r_upper;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sralu_pkg::CFG_IDX_UPPER: prdata = {{(DB-FB){r_upper[FB-1]}}, r_upper};
            sralu_pkg::CFG_IDX_LOWER: prdata = {{(DB-FB){r_lower[FB-1]}}, r_lower};
            default:                  prdata = '0;
        endcase
    end

    sralu_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    sralu_back #(
        .REG_COUNT  (REG_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_upper     (r_upper),
        .i_lower     (r_lower),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the saturating register alu machine
// ----------------------------------------------------------------------------
// A shadow copy of the sixteen registers and the two clamp limits predicts
// register zero and the written value for every command taken on the input
// stream. Each result transfer is checked against the oldest prediction. The
// run starts with directed edge cases, then goes through several limit
// settings, extremes and crossed limits among them, with bursty random
// commands, a stalling receiver and one long receiver hold-off per setting.
module testbench;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam logic [sralu_pkg::CFG_ADDR_BITS-1:0] ADDR_UPPER =
        {sralu_pkg::CFG_IDX_UPPER, 2'b00};
    localparam logic [sralu_pkg::CFG_ADDR_BITS-1:0] ADDR_LOWER =
        {sralu_pkg::CFG_IDX_LOWER, 2'b00};
    localparam int VAL_MAX      = 127;
    localparam int VAL_MIN      = -128;
    localparam int SETTLE_TICKS = 32;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int HOLD_TICKS   = 160;

    // shadow of the register file and limits, with the results still owed
    class shadow_machine;
        logic signed [7:0] regs [16];
        logic signed [7:0] upper;
        logic signed [7:0] lower;
        logic [15:0]       owed_results [$];

        function new();
            foreach (regs[i]) regs[i] = '0;
            upper = sralu_pkg::UPPER_RESET;
            lower = sralu_pkg::LOWER_RESET;
        endfunction

        function void set_limit(logic [sralu_pkg::CFG_ADDR_BITS-1:0] addr,
                logic signed [7:0] v);
            if (addr[2] == sralu_pkg::CFG_IDX_UPPER) upper = v;
            else lower = v;
        endfunction

        function logic signed [7:0] clamp(int v);
            if (v > int'(upper)) v = int'(upper);
            else if (v < int'(lower)) v = int'(lower);
            if (v > VAL_MAX) v = VAL_MAX;
            else if (v < VAL_MIN) v = VAL_MIN;
            return v[7:0];
        endfunction

        function logic signed [7:0] alu_result(sralu_pkg::t_op op, int a, int b);
            case (op)
                sralu_pkg::OP_ADD: return clamp(a + b);
                sralu_pkg::OP_SUB: return clamp(a - b);
                sralu_pkg::OP_MUL: return clamp(a * b);
                default: begin
                    if (b == 0) return a[7:0];
                    // the one quotient that does not fit
                    if (a == VAL_MIN && b == -1) return 8'(VAL_MAX);
                    return 8'(a / b);
                end
            endcase
        endfunction

        function void take_command(logic [1:0] mode,
                logic [sralu_pkg::S_TDATA_BITS-1:0] data);
            logic [3:0]        dst;
            logic [3:0]        s1;
            logic [3:0]        s2;
            sralu_pkg::t_op    op;
            logic signed [7:0] wr;
            dst = data[3:0];
            op  = sralu_pkg::t_op'(data[5:4]);
            s1  = data[9:6];
            s2  = data[13:10];
            wr  = '0;
            case (mode)
                sralu_pkg::MODE_CLEAR: foreach (regs[i]) regs[i] = '0;
                sralu_pkg::MODE_LOAD: begin
                    wr = data[21:14];
                    regs[dst] = wr;
                end
                sralu_pkg::MODE_EXEC: begin
                    wr = alu_result(op, int'(regs[s1]), int'(regs[s2]));
                    regs[dst] = wr;
                end
                default: ;
            endcase
            owed_results.push_back({wr, regs[0]});
        endfunction

        function string check_result(logic [sralu_pkg::M_TDATA_BITS-1:0] data);
            logic [15:0] want;
            string       msg;
            if (owed_results.size() == 0)
                return $sformatf("result %h with nothing owed", data);
            want = owed_results.pop_front();
            msg = "";
            if (data[7:0] !== want[7:0])
                msg = $sformatf("register_a_value %h, want %h ", data[7:0], want[7:0]);
            if (data[15:8] !== want[15:8])
                msg = {msg, $sformatf("written_value %h, want %h", data[15:8], want[15:8])};
            return msg;
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   s_axis_tvalid;
    logic                                   s_axis_tready;
    // target_index, opcode, first_source, second_source, load_value, zero pad
    logic [sralu_pkg::S_TDATA_BITS-1:0]     s_axis_tdata;
    // mode
    logic [sralu_pkg::S_TUSER_BITS-1:0]     s_axis_tuser;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready;
    // register_a_value, written_value
    logic [sralu_pkg::M_TDATA_BITS-1:0]     m_axis_tdata;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [sralu_pkg::CFG_ADDR_BITS-1:0]    paddr;
    logic [sralu_pkg::CFG_DATA_BITS-1:0]    pwdata;
    logic [sralu_pkg::CFG_DATA_BITS-1:0]    prdata;
    logic                                   pready;

    shadow_machine shadow = new();
    int  errors        = 0;
    int  cmds_taken    = 0;
    int  results_seen  = 0;
    bit  rx_hold_req   = 1'b0;

    saturating_register_alu_machine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // both stream monitors sample before the edge updates take effect
    always @(posedge i_clk) begin : monitors
        string msg;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            shadow.take_command(s_axis_tuser, s_axis_tdata);
            cmds_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            msg = shadow.check_result(m_axis_tdata);
            if (msg != "") report_mismatch(msg);
        end
    end

    // receiver: switches between stall patterns, long hold-off on request
    initial begin : receiver
        int style;
        int style_left;
        int hold_left;
        int tick;
        m_axis_tready = 1'b0;
        style = 0;
        style_left = 0;
        hold_left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (rx_hold_req) begin
                hold_left = HOLD_TICKS;
                rx_hold_req = 1'b0;
            end
            if (style_left == 0) begin
                style = $urandom_range(0, 4);
                style_left = $urandom_range(10, 150);
            end
            style_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= 1'($urandom_range(0, 1));
                    3: m_axis_tready <= ((tick % 5) >= 2);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic [sralu_pkg::S_TDATA_BITS-1:0] pack_cmd(logic [3:0] dst,
            sralu_pkg::t_op op, logic [3:0] s1, logic [3:0] s2, logic signed [7:0] val);
        return {2'b00, val, s2, s1, op, dst};
    endfunction

    task automatic send_item(input logic [1:0] mode,
            input logic [sralu_pkg::S_TDATA_BITS-1:0] data);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_reg(input logic [3:0] dst, input logic signed [7:0] val);
        send_item(sralu_pkg::MODE_LOAD, pack_cmd(dst, sralu_pkg::OP_ADD, 4'd0, 4'd0, val));
    endtask

    task automatic exec_cmd(input sralu_pkg::t_op op, input logic [3:0] dst,
            input logic [3:0] s1, input logic [3:0] s2);
        send_item(sralu_pkg::MODE_EXEC, pack_cmd(dst, op, s1, s2, 8'sd0));
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // lower valid, then wait for every owed result plus some settling
    task automatic drain(input int extra);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (shadow.owed() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [sralu_pkg::CFG_ADDR_BITS-1:0] addr,
            input logic signed [7:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {{24{v[7]}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow.set_limit(addr, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(input logic [sralu_pkg::CFG_ADDR_BITS-1:0] addr,
            input logic signed [7:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== want)
            report_mismatch($sformatf("limit at %0d reads %h, want %h", addr,
                prdata[7:0], want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random;
        int                r;
        logic [1:0]        mode;
        logic signed [7:0] val;
        r = $urandom_range(0, 99);
        if (r < 4) mode = sralu_pkg::MODE_CLEAR;
        else if (r < 8) mode = MODE_IGNORED;
        else if (r < 45) mode = sralu_pkg::MODE_LOAD;
        else mode = sralu_pkg::MODE_EXEC;
        case ($urandom_range(0, 9))
            0: val = 8'sd127;
            1: val = -8'sd128;
            2: val = -8'sd1;
            3: val = 8'sd0;
            default: val = 8'($urandom_range(0, 255));
        endcase
        send_item(mode, pack_cmd(4'($urandom_range(0, 15)),
            sralu_pkg::t_op'($urandom_range(0, 3)),
            4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), val));
    endtask

    logic signed [7:0] upper_set [PHASE_COUNT] = '{8'sd127, 8'sd100, -8'sd20, 8'sd127,
        -8'sd128, 8'sd5, -8'sd128, 8'sd127};
    logic signed [7:0] lower_set [PHASE_COUNT] = '{-8'sd128, -8'sd100, 8'sd20, 8'sd127,
        -8'sd128, -8'sd5, 8'sd127, -8'sd128};

    initial begin : stimulus
        int left;
        int blen;
        int gap;
        bit first;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_check(ADDR_UPPER, sralu_pkg::UPPER_RESET);
        cfg_check(ADDR_LOWER, sralu_pkg::LOWER_RESET);

        // edge cases under the reset limits
        exec_cmd(sralu_pkg::OP_ADD, 4'd0, 4'd1, 4'd2);
        load_reg(4'd1, 8'sd127);
        load_reg(4'd2, -8'sd128);
        load_reg(4'd3, -8'sd1);
        load_reg(4'd4, 8'sd1);
        load_reg(4'd15, 8'sd0);
        exec_cmd(sralu_pkg::OP_ADD, 4'd5, 4'd1, 4'd4);
        exec_cmd(sralu_pkg::OP_SUB, 4'd6, 4'd2, 4'd4);
        exec_cmd(sralu_pkg::OP_MUL, 4'd7, 4'd1, 4'd1);
        exec_cmd(sralu_pkg::OP_MUL, 4'd8, 4'd2, 4'd1);
        exec_cmd(sralu_pkg::OP_MUL, 4'd9, 4'd2, 4'd2);
        // most negative over minus one
        exec_cmd(sralu_pkg::OP_DIV, 4'd0, 4'd2, 4'd3);
        // divide by zero keeps the dividend
        exec_cmd(sralu_pkg::OP_DIV, 4'd10, 4'd1, 4'd15);
        exec_cmd(sralu_pkg::OP_DIV, 4'd11, 4'd2, 4'd15);
        load_reg(4'd12, -8'sd7);
        load_reg(4'd13, 8'sd2);
        exec_cmd(sralu_pkg::OP_DIV, 4'd14, 4'd12, 4'd13);
        exec_cmd(sralu_pkg::OP_DIV, 4'd14, 4'd1, 4'd2);
        exec_cmd(sralu_pkg::OP_SUB, 4'd0, 4'd2, 4'd1);
        send_item(MODE_IGNORED,
            pack_cmd(4'hf, sralu_pkg::OP_DIV, 4'hf, 4'hf, -8'sd1));
        send_item(sralu_pkg::MODE_CLEAR,
            pack_cmd(4'hf, sralu_pkg::OP_DIV, 4'hf, 4'hf, -8'sd1));
        exec_cmd(sralu_pkg::OP_ADD, 4'd3, 4'd0, 4'd0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                drain(SETTLE_TICKS);
                cfg_write(ADDR_UPPER, upper_set[p]);
                cfg_write(ADDR_LOWER, lower_set[p]);
                cfg_check(ADDR_UPPER, upper_set[p]);
                cfg_check(ADDR_LOWER, lower_set[p]);
            end
            if (upper_set[p] < lower_set[p]) begin
                // crossed limits
                load_reg(4'd1, 8'sd127);
                exec_cmd(sralu_pkg::OP_ADD, 4'd2, 4'd1, 4'd1);
                exec_cmd(sralu_pkg::OP_SUB, 4'd3, 4'd2, 4'd1);
                exec_cmd(sralu_pkg::OP_MUL, 4'd4, 4'd0, 4'd0);
            end
            left = PHASE_ITEMS;
            first = 1'b1;
            while (left > 0) begin
                if (first) begin
                    // long receiver hold-off while the sender keeps offering
                    blen = 40;
                    gap = 0;
                    rx_hold_req = 1'b1;
                end else begin
                    blen = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if ($urandom_range(0, 9) == 0) drain(0);
                end
                if (blen > left) blen = left;
                idle_sender(gap);
                repeat (blen) send_random();
                left -= blen;
                first = 1'b0;
            end
        end

        drain(SETTLE_TICKS);
        $display("tb: %0d commands taken, %0d results checked", cmds_taken, results_seen);
        $display("tb: %0d limit settings, crossed and equal limits among them", PHASE_COUNT);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb: timeout");
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: saturating_register_alu_machine.f
+incdir+sv
sv/sralu_pkg.sv
sv/sralu_front.sv
sv/sralu_div.sv
sv/sralu_back.sv
sv/saturating_register_alu_machine.sv
sim/testbench.sv
